/* rtl/alse_pkg.sv */
// package for the airfoil level-set evaluator: types, constants and helpers
`timescale 1ns / 1ps

package alse_pkg;

    localparam int QB = 20;

    localparam int COS_W   = 22;
    localparam int SIN_W   = 22;
    localparam int ORG_W   = 25;
    localparam int PIV_W   = 23;
    localparam int RAD_W   = 21;
    localparam int CHORD_W = 22;
    localparam int POS_W   = 25;
    localparam int PHI_W   = 32;
    localparam int CFG_W   = 25;
    localparam int IDX_W   = 3;

    localparam int X_W  = 29;
    localparam int XC_W = 22;
    localparam int SQ_W = 21;
    localparam int SQ_STAGES = 7;
    localparam int SQ_STEPS  = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_COS   = 3'd0,
        CFG_SIN   = 3'd1,
        CFG_ORG_X = 3'd2,
        CFG_ORG_Y = 3'd3,
        CFG_PIV_X = 3'd4,
        CFG_PIV_Y = 3'd5,
        CFG_RAD   = 3'd6,
        CFG_CHORD = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REG_NOSE  = 2'd0,
        REG_THICK = 2'd1,
        REG_BEYOND = 2'd2
    } t_region;

    localparam logic signed [PHI_W-1:0] PHI_OUTSIDE = -32'sd1048576;

    localparam logic [18:0] K_SQRT  = 19'd311322;
    localparam logic [17:0] K_LIN   = 18'd132121;
    localparam logic [18:0] K_SQ    = 19'd368679;
    localparam logic [18:0] K_CUBE  = 19'd298110;
    localparam logic [16:0] K_QUART = 17'd108632;
    localparam logic [19:0] K_THICK = 20'd786432;

    typedef struct packed {
        logic [41:0] rem;
        logic [42:0] res;
    } t_sq;

    function automatic t_sq sq_step(t_sq s, int k);
        logic [43:0] b;
        logic [43:0] t;
        t_sq r;
        b = 44'(1) << (40 - 2 * k);
        t = {1'b0, s.res} + b;
        if ({2'b0, s.rem} >= t) begin
            r.rem = s.rem - t[41:0];
            r.res = (s.res >> 1) + b[42:0];
        end else begin
            r.rem = s.rem;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic logic signed [PHI_W-1:0] sat_phi(logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[PHI_W-1:0];
    endfunction

    typedef struct packed {
        t_region                  region;
        logic signed [57:0]       yy;
        logic signed [PHI_W-1:0]  phin;
    } t_side;

endpackage

/* rtl/alse_in_if.sv */
// input word channel: one grid point
`timescale 1ns / 1ps

interface alse_in_if
    import alse_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink (input valid, pos_x, pos_y, output ready);
endinterface

/* rtl/alse_out_if.sv */
// output word channel: level-set value and region
`timescale 1ns / 1ps

interface alse_out_if
    import alse_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [PHI_W-1:0] phi;
    logic [1:0]              region;

    modport source (output valid, phi, region, input ready);
    modport sink (input valid, phi, region, output ready);
endinterface

/* rtl/alse_sqrt.sv */
// pipelined digit-by-digit square root of xc * 2^20, three digits per stage
`timescale 1ns / 1ps

module alse_sqrt
    import alse_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_ce,
    input  logic [XC_W-1:0] i_xc,
    output logic [SQ_W-1:0] o_sq
);

    t_sq r_st [SQ_STAGES];
    t_sq n_st [SQ_STAGES];

    always_comb begin
        t_sq s;
        for (int g = 0; g < SQ_STAGES; g++) begin
            if (g == 0) begin
                s.rem = {i_xc, 20'd0};
                s.res = '0;
            end else begin
                s = r_st[g-1];
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                s = sq_step(s, g * SQ_STEPS + k);
            end
            n_st[g] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int g = 0; g < SQ_STAGES; g++) begin
                r_st[g] <= n_st[g];
            end
        end
    end

    assign o_sq = r_st[SQ_STAGES-1].res[SQ_W-1:0];

endmodule

/* rtl/airfoil_level_set_eval_unit.sv */
// top level: pitching symmetric airfoil level-set evaluator
`timescale 1ns / 1ps
// usage
// - i_pt carries one grid point (pos_x, pos_y) per word, o_res one word
//   (phi, region) per point, in order, valid/ready on both sides
// - configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is
//   high; write only while no point is in flight
// - throughput: one point per cycle unless o_res stalls; the square root
//   runs as seven stages of three digits, every other stage holds one
//   product or one short sum on any path
// - a stall on o_res freezes the whole pipe; i_pt.ready drops until the
//   held word is taken, so nothing is lost or repeated
// - reset empties the pipe and loads the default pose registers

module airfoil_level_set_eval_unit
    import alse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    alse_in_if.sink          i_pt,
    alse_out_if.source       o_res
);

    localparam int NST = 15;

    logic signed [COS_W-1:0]   r_cos;
    logic signed [SIN_W-1:0]   r_sin;
    logic [ORG_W-1:0]          r_ox, r_oy;
    logic signed [PIV_W-1:0]   r_px, r_py;
    logic [RAD_W-1:0]          r_rad;
    logic [CHORD_W-1:0]        r_chord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= 22'sd1048576;
            r_sin   <= '0;
            r_ox    <= 25'd5242880;
            r_oy    <= 25'd10485760;
            r_px    <= 23'sd262144;
            r_py    <= '0;
            r_rad   <= 21'd25995;
            r_chord <= 22'd1048576;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COS:   r_cos   <= i_cfg_data[COS_W-1:0];
                CFG_SIN:   r_sin   <= i_cfg_data[SIN_W-1:0];
                CFG_ORG_X: r_ox    <= i_cfg_data[ORG_W-1:0];
                CFG_ORG_Y: r_oy    <= i_cfg_data[ORG_W-1:0];
                CFG_PIV_X: r_px    <= i_cfg_data[PIV_W-1:0];
                CFG_PIV_Y: r_py    <= i_cfg_data[PIV_W-1:0];
                CFG_RAD:   r_rad   <= i_cfg_data[RAD_W-1:0];
                CFG_CHORD: r_chord <= i_cfg_data[CHORD_W-1:0];
                default: ;
            endcase
        end
    end

    logic            ce;
    logic [NST:1]    r_vld;

    assign ce = !r_vld[NST] || o_res.ready;
    assign i_pt.ready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NST-1:1], i_pt.valid};
        end
    end

    // frame transform
    logic signed [25:0]      r1_dx, r1_dy;
    logic signed [47:0]      r2_pxc, r2_pys, r2_pxs, r2_pyc;
    logic signed [X_W-1:0]   r3_x, r3_y;
    logic signed [48:0]      n3_u, n3_v;

    assign n3_u = 49'(r2_pxc) - 49'(r2_pys) + 49'sd524288;
    assign n3_v = 49'(r2_pxs) + 49'(r2_pyc) + 49'sd524288;

    // stage 4
    logic [XC_W-1:0]         n4_xc;
    t_region                 n4_reg;
    logic signed [57:0]      r4_xx, r4_yy;
    logic signed [51:0]      r4_xr;
    logic [XC_W-1:0]         r4_xc;
    t_region                 r4_reg;

    always_comb begin
        if (r3_x < 0) begin
            n4_reg = REG_NOSE;
        end else if (r3_x <= $signed({7'd0, r_chord})) begin
            n4_reg = REG_THICK;
        end else begin
            n4_reg = REG_BEYOND;
        end
        n4_xc = (n4_reg == REG_THICK) ? r3_x[XC_W-1:0] : '0;
    end

    // stages 5..14
    logic [23:0]             r5_x2;
    logic [XC_W-1:0]         r5_xc;
    logic signed [59:0]      n5_v;
    logic signed [PHI_W-1:0] n5_phin;
    logic [25:0]             r6_x3;
    logic [27:0]             r6_x4;
    logic [23:0]             r6_x2;
    logic [XC_W-1:0]         r6_xc;
    logic [44:0]             r7_tl, r7_tq, r7_tc, r7_t4;
    logic signed [47:0]      r8_part;
    logic signed [47:0]      r9_part, r10_part, r11_part;
    logic [39:0]             r11_ts;
    logic signed [48:0]      n12_s;
    logic signed [28:0]      r12_poly;
    logic signed [48:0]      n13_p;
    logic signed [29:0]      r13_yt;
    logic signed [59:0]      r14_yt2;
    logic [SQ_W-1:0]         sq;
    t_side                   r_sd [5:14];
    t_side                   n5_sd;
    logic signed [60:0]      n15_v;
    logic signed [PHI_W-1:0] n15_phi;
    logic signed [PHI_W-1:0] r15_phi;
    t_region                 r15_reg;

    assign n5_v = 60'(r4_xr) - 60'(r4_xx) - 60'(r4_yy) + 60'sd524288;
    assign n5_phin = sat_phi(42'(n5_v >>> QB));
    assign n5_sd = '{region: r4_reg, yy: r4_yy, phin: n5_phin};

    assign n12_s = 49'($signed({1'b0, r11_ts})) + 49'(r11_part) + 49'sd524288;
    assign n13_p = 49'($signed({1'b0, K_THICK})) * 49'(r12_poly) + 49'sd524288;
    assign n15_v = 61'(r14_yt2) - 61'(r_sd[14].yy) + 61'sd524288;

    always_comb begin
        case (r_sd[14].region)
            REG_NOSE:  n15_phi = r_sd[14].phin;
            REG_THICK: n15_phi = sat_phi(42'(n15_v >>> QB));
            default:   n15_phi = PHI_OUTSIDE;
        endcase
    end

    alse_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_xc  (n4_xc),
        .o_sq  (sq)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_dx <= $signed({1'b0, i_pt.pos_x}) - $signed({1'b0, r_ox});
            r1_dy <= $signed({1'b0, i_pt.pos_y}) - $signed({1'b0, r_oy});

            r2_pxc <= 48'(r1_dx) * 48'(r_cos);
            r2_pys <= 48'(r1_dy) * 48'(r_sin);
            r2_pxs <= 48'(r1_dx) * 48'(r_sin);
            r2_pyc <= 48'(r1_dy) * 48'(r_cos);

            r3_x <= X_W'(49'(r_px) + (n3_u >>> QB));
            r3_y <= X_W'(49'(r_py) + (n3_v >>> QB));

            r4_xx  <= 58'(r3_x) * 58'(r3_x);
            r4_yy  <= 58'(r3_y) * 58'(r3_y);
            r4_xr  <= (52'(r3_x) * 52'($signed({1'b0, r_rad}))) <<< 1;
            r4_xc  <= n4_xc;
            r4_reg <= n4_reg;

            r5_x2    <= 24'((r4_xx + 58'sd524288) >>> QB);
            r5_xc    <= r4_xc;
            r_sd[5]  <= n5_sd;

            r6_x3 <= 26'(((46'(r5_x2) * 46'(r5_xc)) + 46'd524288) >> QB);
            r6_x4 <= 28'(((48'(r5_x2) * 48'(r5_x2)) + 48'd524288) >> QB);
            r6_x2 <= r5_x2;
            r6_xc <= r5_xc;

            r7_tl <= 45'(K_LIN) * 45'(r6_xc);
            r7_tq <= 45'(K_SQ) * 45'(r6_x2);
            r7_tc <= 45'(K_CUBE) * 45'(r6_x3);
            r7_t4 <= 45'(K_QUART) * 45'(r6_x4);

            r8_part <= $signed(48'(r7_tc)) - $signed(48'(r7_tl))
                     - $signed(48'(r7_tq)) - $signed(48'(r7_t4));
            r9_part  <= r8_part;
            r10_part <= r9_part;
            r11_part <= r10_part;
            r11_ts   <= 40'(K_SQRT) * 40'(sq);

            r12_poly <= 29'(n12_s >>> QB);
            r13_yt   <= 30'(n13_p >>> QB);
            r14_yt2  <= 60'(r13_yt) * 60'(r13_yt);

            for (int s = 6; s <= 14; s++) begin
                r_sd[s] <= r_sd[s-1];
            end

            r15_phi <= n15_phi;
            r15_reg <= r_sd[14].region;
        end
    end

    assign o_res.valid  = r_vld[NST];
    assign o_res.phi    = r15_phi;
    assign o_res.region = r15_reg;

endmodule

/* rtl/alse_chk.sv */
// port-level checker for the airfoil level-set evaluator, with its bind
`timescale 1ns / 1ps

module alse_chk
    import alse_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_ready,
    input  logic                    o_valid,
    input  logic                    o_ready,
    input  logic signed [PHI_W-1:0] o_phi,
    input  logic [1:0]              o_region
);

    // no word leaves right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    a_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_region == REG_NOSE || o_region == REG_THICK
                     || o_region == REG_BEYOND))
        else $error("bad region code");

    a_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region == REG_BEYOND) |-> o_phi == PHI_OUTSIDE)
        else $error("beyond chord word with wrong phi");

    // input is held off while an output word stalls
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |-> !i_ready)
        else $error("input taken during output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> o_valid && $stable(o_phi) && $stable(o_region))
        else $error("stalled output word changed");

endmodule

bind airfoil_level_set_eval_unit alse_chk u_alse_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_pt.valid),
    .i_ready  (i_pt.ready),
    .o_valid  (o_res.valid),
    .o_ready  (o_res.ready),
    .o_phi    (o_res.phi),
    .o_region (o_res.region)
);

/* sim/tb_airfoil_level_set_eval_unit.sv */
// testbench for the airfoil level-set evaluator: predicts phi and region per grid point
`timescale 1ns / 1ps

module tb_airfoil_level_set_eval_unit;
    import alse_pkg::*;

    typedef struct {
        logic signed [PHI_W-1:0] phi;
        logic [1:0]              region;
    } t_level;

    class level_board;
        t_level pending[$];
        int     errors;
        logic [CFG_W-1:0] regs[8];

        function new();
            errors = 0;
            regs[CFG_COS]   = 25'd1048576;
            regs[CFG_SIN]   = 25'd0;
            regs[CFG_ORG_X] = 25'd5242880;
            regs[CFG_ORG_Y] = 25'd10485760;
            regs[CFG_PIV_X] = 25'd262144;
            regs[CFG_PIV_Y] = 25'd0;
            regs[CFG_RAD]   = 25'd25995;
            regs[CFG_CHORD] = 25'd1048576;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
            regs[idx] = v;
        endfunction

        static function longint rq(longint v);
            return (v + 64'sd524288) >>> 20;
        endfunction

        static function longint root_q20(longint xq);
            longint unsigned n, res, b;
            n = longint'(xq) << 20;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return longint'(res);
        endfunction

        function t_level level_at(logic [POS_W-1:0] px_in, logic [POS_W-1:0] py_in);
            longint cs, sn, pvx, pvy, rad, chord, dx, dy, xx, yy, ph;
            longint sq, x2, x3, x4, poly, yt;
            t_level r;
            cs    = longint'(signed'(regs[CFG_COS][COS_W-1:0]));
            sn    = longint'(signed'(regs[CFG_SIN][SIN_W-1:0]));
            pvx   = longint'(signed'(regs[CFG_PIV_X][PIV_W-1:0]));
            pvy   = longint'(signed'(regs[CFG_PIV_Y][PIV_W-1:0]));
            rad   = longint'(regs[CFG_RAD][RAD_W-1:0]);
            chord = longint'(regs[CFG_CHORD][CHORD_W-1:0]);
            dx = longint'(px_in) - longint'(regs[CFG_ORG_X]);
            dy = longint'(py_in) - longint'(regs[CFG_ORG_Y]);
            xx = pvx + rq(dx * cs - dy * sn);
            yy = pvy + rq(dx * sn + dy * cs);
            if (xx < 0) begin
                ph = rq(2 * xx * rad - xx * xx - yy * yy);
                r.region = REG_NOSE;
            end else if (xx <= chord) begin
                sq = root_q20(xx);
                x2 = rq(xx * xx);
                x3 = rq(x2 * xx);
                x4 = rq(x2 * x2);
                poly = rq(311322 * sq - 132121 * xx - 368679 * x2
                          + 298110 * x3 - 108632 * x4);
                yt = rq(786432 * poly);
                ph = rq(yt * yt - yy * yy);
                r.region = REG_THICK;
            end else begin
                ph = -1048576;
                r.region = REG_BEYOND;
            end
            if (ph > 64'sd2147483647) ph = 64'sd2147483647;
            if (ph < -64'sd2147483648) ph = -64'sd2147483648;
            r.phi = ph[31:0];
            return r;
        endfunction

        function void note_point(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
            pending.push_back(level_at(x, y));
        endfunction

        task check_level(logic signed [PHI_W-1:0] phi, logic [1:0] region);
            t_level e;
            if (pending.size() == 0) begin
                report_error("word with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (phi !== e.phi)
                report_error($sformatf("phi %0d, predicted %0d", phi, e.phi));
            if (region !== e.region)
                report_error($sformatf("region %0d, predicted %0d", region, e.region));
        endtask

        task report_error(string msg);
            errors++;
            if (errors <= 40) $display("error: %s", msg);
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    alse_in_if  pt_if();
    alse_out_if res_if();

    airfoil_level_set_eval_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pt(pt_if.sink), .o_res(res_if.source)
    );

    level_board board;
    int         idle_cycles;
    int         stall_mode;
    int         stall_phase;

    localparam int WATCHDOG = 4000;
    localparam logic [POS_W-1:0] POS_MAX = 25'd20971520;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 3) != 0);
            2: res_if.ready <= (stall_phase % 7) < 3;
            default: res_if.ready <= ($urandom_range(0, 9) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_level(res_if.phi, res_if.region);
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("airfoil_level_set_eval_unit: mismatch");
            $finish;
        end
    end

    task automatic send_point(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        pt_if.valid <= 1'b1;
        pt_if.pos_x <= x;
        pt_if.pos_y <= y;
        do @(posedge i_clk); while (!pt_if.ready);
        board.note_point(x, y);
    endtask

    task automatic pause_sender(int n);
        pt_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_reg(idx, v);
    endtask

    // point near the airfoil: origin plus a small offset
    function automatic logic [POS_W-1:0] near_pos(logic [CFG_W-1:0] org);
        longint v;
        v = longint'(org) + $signed($urandom_range(0, 4194304)) - 2097152;
        if (v < 0) v = 0;
        if (v > 20971520) v = 20971520;
        return v[POS_W-1:0];
    endfunction

    task automatic random_points(int n);
        int burst;
        logic [POS_W-1:0] x, y;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if ($urandom_range(0, 4) == 0) begin
                    x = POS_W'($urandom_range(0, 20971520));
                    y = POS_W'($urandom_range(0, 20971520));
                end else begin
                    x = near_pos(board.regs[CFG_ORG_X]);
                    y = near_pos(board.regs[CFG_ORG_Y]);
                end
                send_point(x, y);
                n--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
        end
    endtask

    task automatic write_pose(int c, int s, int ox, int oy, int pvx, int pvy,
                              int rad, int chord);
        write_reg(CFG_COS, c[CFG_W-1:0]);
        write_reg(CFG_SIN, s[CFG_W-1:0]);
        write_reg(CFG_ORG_X, ox[CFG_W-1:0]);
        write_reg(CFG_ORG_Y, oy[CFG_W-1:0]);
        write_reg(CFG_PIV_X, pvx[CFG_W-1:0]);
        write_reg(CFG_PIV_Y, pvy[CFG_W-1:0]);
        write_reg(CFG_RAD, rad[CFG_W-1:0]);
        write_reg(CFG_CHORD, chord[CFG_W-1:0]);
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_COS;
        i_cfg_data = '0;
        pt_if.valid = 1'b0;
        pt_if.pos_x = '0;
        pt_if.pos_y = '0;
        res_if.ready = 1'b0;
        stall_mode = 0;
        stall_phase = 0;
        idle_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset pose, field extremes, edges of the chord
        send_point('0, '0);
        send_point(POS_MAX, POS_MAX);
        send_point(25'h1FFFFFF, 25'h1FFFFFF);
        send_point(25'h1555555, 25'h0AAAAAA);
        send_point(25'h0AAAAAA, 25'h1555555);
        send_point(25'd5242880 - 25'd262144, 25'd10485760);
        send_point(25'd5242880 + 25'd786432, 25'd10485760);
        send_point(25'd5242880 + 25'd786433, 25'd10485760);
        send_point(25'd5242880 - 25'd262145, 25'd10485760 + 25'd1000);
        send_point(25'd5242880, 25'd10485760 + 25'd20000);
        send_point(25'd5242880 + 25'd262144, 25'd10485760 - 25'd50000);
        drain();

        // zero chord, large radius, odd pivot
        write_pose(0, 0, 0, 0, -2097152, 2097152, 1048576, 0);
        send_point(25'd5, 25'd7);
        drain();
        write_reg(CFG_COS, 25'd1048576);
        send_point(25'd2097152, 25'd0);
        send_point(25'd2097153, 25'd0);
        send_point(25'd2097151, 25'd3);
        drain();

        // unnormalised pose, long chord so the thickness goes negative
        write_pose(-1048576, 1048576, 20971520, 20971520, 2097152, -2097152,
                   0, 2097152);
        send_point(POS_MAX, 25'd0);
        send_point(25'd19922944, POS_MAX);
        send_point(25'd0, 25'd0);
        random_points(60);
        drain();

        stall_mode = 1;
        write_pose(1048576, 0, 5242880, 10485760, 262144, 0, 25995, 1048576);
        random_points(250);
        drain();

        write_pose(1016000, 259000, 5242880, 10485760, 262144, 0, 25995, 1048576);
        random_points(220);
        drain();

        stall_mode = 2;
        write_pose(-740000, -742000, 3000000, 15000000, -500000, 300000,
                   400000, 2097152);
        random_points(200);
        drain();

        write_pose($urandom_range(0, 2097152) - 1048576,
                   $urandom_range(0, 2097152) - 1048576,
                   $urandom_range(0, 20971520), $urandom_range(0, 20971520),
                   $urandom_range(0, 4194304) - 2097152,
                   $urandom_range(0, 4194304) - 2097152,
                   $urandom_range(0, 1048576), $urandom_range(0, 2097152));
        random_points(200);
        drain();

        if (board.errors == 0)
            $display("airfoil_level_set_eval_unit: match");
        else
            $display("airfoil_level_set_eval_unit: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
rtl/alse_pkg.sv
rtl/alse_in_if.sv
rtl/alse_out_if.sv
rtl/alse_sqrt.sv
rtl/airfoil_level_set_eval_unit.sv
rtl/alse_chk.sv
sim/tb_airfoil_level_set_eval_unit.sv
